/* rtl/command_frame_builder_xor_macros.svh */
// Assertion macros for the command frame builder
`ifndef COMMAND_FRAME_BUILDER_XOR_MACROS_SVH
`define COMMAND_FRAME_BUILDER_XOR_MACROS_SVH

// same-cycle implication, disabled in reset
`define CFB_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cfb assertion failed");

// next-cycle implication, disabled in reset
`define CFB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cfb assertion failed");

`endif

/* rtl/cfb_pkg.sv */
// Shared types and constants of the command frame builder
package cfb_pkg;

  localparam int MaxPayloadDefault = 64;
  localparam int QueueDepthDefault = 4;
  localparam logic [7:0] LenOverhead = 8'd6;
  localparam logic [7:0] HeaderReset = 8'hAA;
  localparam logic [7:0] AddrReset   = 8'h00;
  localparam logic [7:0] Instr2Reset = 8'h00;

  typedef enum logic [1:0] {
    REG_HEADER  = 2'd0,
    REG_ADDRESS = 2'd1,
    REG_INSTR2  = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic       first;
    logic       zero_len;
    logic       last;
    logic [7:0] hdr_byte;
    logic [7:0] dev_addr;
    logic [7:0] len_byte;
    logic [7:0] instr;
    logic [7:0] instr2;
    logic [7:0] payload;
  } cmd_t;

  typedef struct packed {
    logic push;
    cmd_t cmd;
  } push_t;

  typedef struct packed {
    logic empty;
    cmd_t head;
  } head_t;

endpackage

/* rtl/cfb_front.sv */
// Front end: configuration registers, frame tracking and command classification
module cfb_front #(
  parameter int MAX_PAYLOAD = cfb_pkg::MaxPayloadDefault
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_we,
  input  logic [1:0]     cfg_index,
  input  logic [7:0]     cfg_wdata,
  input  logic           in_valid,
  input  logic           in_first_item,
  input  logic [7:0]     in_instruction,
  input  logic [6:0]     in_payload_len,
  input  logic [7:0]     in_payload_byte,
  input  logic           q_full,
  output logic           in_stall,
  output cfb_pkg::push_t push
);

  localparam logic [7:0] MaxLen = 8'(MAX_PAYLOAD);

  logic [7:0] hdr_r, addr_r, instr2_r;
  logic       open_r, open_nxt;
  logic [6:0] remain_r, remain_nxt;
  logic       accept;
  logic [7:0] len_ext, len_sat;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign len_ext  = {1'b0, in_payload_len};
  assign len_sat  = (len_ext > MaxLen) ? MaxLen : len_ext;

  always_comb begin
    open_nxt          = open_r;
    remain_nxt        = remain_r;
    push.push         = 1'b0;
    push.cmd.first    = in_first_item;
    push.cmd.zero_len = (len_sat == 8'd0);
    push.cmd.last     = 1'b0;
    push.cmd.hdr_byte = hdr_r;
    push.cmd.dev_addr = addr_r;
    push.cmd.len_byte = len_sat + cfb_pkg::LenOverhead;
    push.cmd.instr    = in_instruction;
    push.cmd.instr2   = instr2_r;
    push.cmd.payload  = in_payload_byte;
    if (accept) begin
      if (in_first_item) begin
        push.push     = 1'b1;
        push.cmd.last = (len_sat == 8'd1);
        open_nxt      = (len_sat > 8'd1);
        remain_nxt    = (len_sat == 8'd0) ? 7'd0 : 7'(len_sat - 8'd1);
      end else if (open_r && remain_r != 7'd0) begin
        push.push     = 1'b1;
        push.cmd.last = (remain_r == 7'd1);
        open_nxt      = (remain_r != 7'd1);
        remain_nxt    = remain_r - 7'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_r    <= cfb_pkg::HeaderReset;
      addr_r   <= cfb_pkg::AddrReset;
      instr2_r <= cfb_pkg::Instr2Reset;
      open_r   <= 1'b0;
      remain_r <= 7'd0;
    end else begin
      open_r   <= open_nxt;
      remain_r <= remain_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          cfb_pkg::REG_HEADER:  hdr_r    <= cfg_wdata;
          cfb_pkg::REG_ADDRESS: addr_r   <= cfg_wdata;
          cfb_pkg::REG_INSTR2:  instr2_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

endmodule

/* rtl/cfb_queue.sv */
// Command queue between front end and byte engine
module cfb_queue #(
  parameter int DEPTH = cfb_pkg::QueueDepthDefault
) (
  input  logic           clk,
  input  logic           rst_n,
  input  cfb_pkg::push_t push,
  input  logic           pop,
  output logic           full,
  output cfb_pkg::head_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LastPtr = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FullCnt = CW'(DEPTH);

  cfb_pkg::cmd_t mem_r [DEPTH];
  logic [PW-1:0] wptr_r, rptr_r;
  logic [CW-1:0] cnt_r;

  assign full       = (cnt_r == FullCnt);
  assign head.empty = (cnt_r == '0);
  assign head.head  = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push.push) begin
      mem_r[wptr_r] <= push.cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push.push) begin
        wptr_r <= (wptr_r == LastPtr) ? '0 : wptr_r + 1'b1;
      end
      if (pop) begin
        rptr_r <= (rptr_r == LastPtr) ? '0 : rptr_r + 1'b1;
      end
      if (push.push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push.push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

/* rtl/cfb_back.sv */
// Byte engine: serializes commands into frame bytes with running XOR check
`include "command_frame_builder_xor_macros.svh"
module cfb_back (
  input  logic           clk,
  input  logic           rst_n,
  input  cfb_pkg::head_t head,
  output logic           pop,
  input  logic           out_stall,
  output logic           out_valid,
  output logic [7:0]     out_byte,
  output logic           out_frame_end
);

  typedef enum logic [2:0] {
    ST_HDR0, ST_HDR1, ST_HDR2, ST_HDR3, ST_HDR4, ST_PAY, ST_CHK
  } step_t;

  step_t      step_r, cur_step, step_nxt;
  logic       busy_r, busy_nxt;
  logic [7:0] xor_r, xor_nxt;
  logic       valid_r;
  logic [7:0] byte_r;
  logic       end_r;
  logic       load;
  logic [7:0] sel_byte;

  assign out_valid     = valid_r;
  assign out_byte      = byte_r;
  assign out_frame_end = end_r;

  assign cur_step = busy_r ? step_r : (head.head.first ? ST_HDR0 : ST_PAY);
  assign load     = !head.empty && (!valid_r || !out_stall);

  always_comb begin
    sel_byte = xor_r;
    step_nxt = cur_step;
    busy_nxt = 1'b1;
    xor_nxt  = xor_r;
    pop      = 1'b0;
    unique case (cur_step)
      ST_HDR0: begin
        sel_byte = head.head.hdr_byte;
        step_nxt = ST_HDR1;
        xor_nxt  = sel_byte;
      end
      ST_HDR1: begin
        sel_byte = head.head.dev_addr;
        step_nxt = ST_HDR2;
        xor_nxt  = xor_r ^ sel_byte;
      end
      ST_HDR2: begin
        sel_byte = head.head.len_byte;
        step_nxt = ST_HDR3;
        xor_nxt  = xor_r ^ sel_byte;
      end
      ST_HDR3: begin
        sel_byte = head.head.instr;
        step_nxt = ST_HDR4;
        xor_nxt  = xor_r ^ sel_byte;
      end
      ST_HDR4: begin
        sel_byte = head.head.instr2;
        step_nxt = head.head.zero_len ? ST_CHK : ST_PAY;
        xor_nxt  = xor_r ^ sel_byte;
      end
      ST_PAY: begin
        sel_byte = head.head.payload;
        step_nxt = ST_CHK;
        xor_nxt  = xor_r ^ sel_byte;
        busy_nxt = head.head.last;
        pop      = load && !head.head.last;
      end
      ST_CHK: begin
        sel_byte = xor_r;
        xor_nxt  = 8'd0;
        busy_nxt = 1'b0;
        pop      = load;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= ST_HDR0;
      busy_r  <= 1'b0;
      xor_r   <= 8'd0;
      valid_r <= 1'b0;
    end else begin
      if (load) begin
        step_r  <= step_nxt;
        busy_r  <= busy_nxt;
        xor_r   <= xor_nxt;
        valid_r <= 1'b1;
        byte_r  <= sel_byte;
        end_r   <= (cur_step == ST_CHK);
      end else if (!out_stall) begin
        valid_r <= 1'b0;
      end
    end
  end

  `CFB_ASSERT_NOW(a_pop_nonempty, pop, !head.empty)
  `CFB_ASSERT_NOW(a_busy_has_cmd, busy_r, !head.empty)
  `CFB_ASSERT_NOW(a_busy_past_start, busy_r, step_r != ST_HDR0)
  `CFB_ASSERT_NEXT(a_chk_clears_xor, load && cur_step == ST_CHK, xor_r == 8'd0)

endmodule

/* rtl/command_frame_builder_xor.sv */
// Top level of the command frame builder with XOR check byte
// Each accepted item becomes at most one queued command; the byte engine then
// emits one frame byte per cycle while out_stall is low. A payload item yields
// its payload byte, followed by the check byte when it is the last of its frame.
// The first item of a frame yields six bytes: five header bytes, then the check
// byte for zero length or its own payload byte otherwise. It yields seven when
// its length is one, because the check byte follows its payload byte.
// The output byte register is the limit: input is taken every cycle while the
// command queue (QUEUE_DEPTH entries) has room, so the header bytes of a first
// item can fill it and stall later items. Payload lengths above MAX_PAYLOAD
// saturate. A non-first item with no frame open is accepted and dropped.
module command_frame_builder_xor #(
  parameter int MAX_PAYLOAD = cfb_pkg::MaxPayloadDefault,
  parameter int QUEUE_DEPTH = cfb_pkg::QueueDepthDefault
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_first_item,
  input  logic [7:0] in_instruction,
  input  logic [6:0] in_payload_len,
  input  logic [7:0] in_payload_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_frame_end
);

  cfb_pkg::push_t push;
  cfb_pkg::head_t head;
  logic           q_full;
  logic           pop;

  cfb_front #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_first_item  (in_first_item),
    .in_instruction (in_instruction),
    .in_payload_len (in_payload_len),
    .in_payload_byte(in_payload_byte),
    .q_full         (q_full),
    .in_stall       (in_stall),
    .push           (push)
  );

  cfb_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .push (push),
    .pop  (pop),
    .full (q_full),
    .head (head)
  );

  cfb_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head         (head),
    .pop          (pop),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .out_byte     (out_byte),
    .out_frame_end(out_frame_end)
  );

endmodule

/* sim/tb_command_frame_builder_xor.sv */
// Testbench for command_frame_builder_xor: directed and random frames checked beat by beat
`timescale 1ns / 100ps

module tb_command_frame_builder_xor;

  localparam int MaxPayload = cfb_pkg::MaxPayloadDefault;
  localparam int SettleCycles = 40;
  localparam int RandomItems = 350;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } frame_byte_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_SOME,
    STALL_HEAVY
  } stall_mode_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [7:0] cfg_wdata;
  logic       in_valid;
  logic       in_stall;
  logic       in_first_item;
  logic [7:0] in_instruction;
  logic [6:0] in_payload_len;
  logic [7:0] in_payload_byte;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic       out_frame_end;

  logic [7:0] header_reg = cfb_pkg::HeaderReset;
  logic [7:0] address_reg = cfb_pkg::AddrReset;
  logic [7:0] instr2_reg = cfb_pkg::Instr2Reset;
  logic [7:0] frame_xor = 8'h00;
  logic [6:0] bytes_left = 7'd0;
  logic       frame_open = 1'b0;

  frame_byte_t expected_bytes[$];
  int          mismatches = 0;
  int          burst_left = 0;
  stall_mode_t stall_mode = STALL_NONE;
  int          stall_left = 0;

  command_frame_builder_xor uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_first_item   (in_first_item),
    .in_instruction  (in_instruction),
    .in_payload_len  (in_payload_len),
    .in_payload_byte (in_payload_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_frame_end   (out_frame_end)
  );

  always #5 clk = ~clk;

  function automatic void push_frame_byte(logic [7:0] b, logic last);
    frame_byte_t fb;
    fb.data = b;
    fb.last = last;
    expected_bytes.push_back(fb);
    frame_xor = frame_xor ^ b;
  endfunction

  function automatic void take_payload_byte(logic [7:0] data);
    push_frame_byte(data, 1'b0);
    bytes_left = bytes_left - 7'd1;
    if (bytes_left == 7'd0) begin
      push_frame_byte(frame_xor, 1'b1);
      frame_open = 1'b0;
      frame_xor = 8'h00;
    end
  endfunction

  function automatic void predict_frame_bytes(logic first, logic [7:0] instr,
                                              logic [6:0] len, logic [7:0] data);
    logic [6:0] eff_len;
    if (first) begin
      eff_len = (len > MaxPayload) ? 7'(MaxPayload) : len;
      frame_xor = 8'h00;
      push_frame_byte(header_reg, 1'b0);
      push_frame_byte(address_reg, 1'b0);
      push_frame_byte(8'(eff_len) + cfb_pkg::LenOverhead, 1'b0);
      push_frame_byte(instr, 1'b0);
      push_frame_byte(instr2_reg, 1'b0);
      if (eff_len == 7'd0) begin
        push_frame_byte(frame_xor, 1'b1);
        frame_open = 1'b0;
        frame_xor = 8'h00;
        bytes_left = 7'd0;
      end else begin
        frame_open = 1'b1;
        bytes_left = eff_len;
        take_payload_byte(data);
      end
    end else if (frame_open && bytes_left != 7'd0) begin
      take_payload_byte(data);
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("[%0t] mismatch on %s: got %02h, expected %02h", $time, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin : check_beats
    frame_byte_t want;
    if (rst_n) begin
      if (in_valid && !in_stall)
        predict_frame_bytes(in_first_item, in_instruction, in_payload_len, in_payload_byte);
      if (out_valid && !out_stall) begin
        if (expected_bytes.size() == 0) begin
          report_mismatch("unexpected beat", out_byte, 8'h00);
        end else begin
          want = expected_bytes.pop_front();
          if (out_byte !== want.data)
            report_mismatch("out_byte", out_byte, want.data);
          if (out_frame_end !== want.last)
            report_mismatch("out_frame_end", {7'd0, out_frame_end}, {7'd0, want.last});
        end
      end
    end
  end

  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(0, 2));
      stall_left <= $urandom_range(20, 150);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_SOME:  out_stall <= ($urandom_range(0, 3) == 0);
      default:     out_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  task automatic send_item(input logic first, input logic [7:0] instr,
                           input logic [6:0] len, input logic [7:0] data);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 16);
    end
    in_valid        <= 1'b1;
    in_first_item   <= first;
    in_instruction  <= instr;
    in_payload_len  <= len;
    in_payload_byte <= data;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
    @(negedge clk);
  endtask

  task automatic wait_for_results;
    in_valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic write_register(input cfb_pkg::cfg_reg_t sel, input logic [7:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= sel;
    cfg_wdata <= value;
    case (sel)
      cfb_pkg::REG_HEADER:  header_reg = value;
      cfb_pkg::REG_ADDRESS: address_reg = value;
      default:              instr2_reg = value;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic write_all_registers(input logic [7:0] hdr, input logic [7:0] addr,
                                     input logic [7:0] instr2);
    write_register(cfb_pkg::REG_HEADER, hdr);
    write_register(cfb_pkg::REG_ADDRESS, addr);
    write_register(cfb_pkg::REG_INSTR2, instr2);
  endtask

  task automatic test_zero_length;
    send_item(1'b1, 8'h00, 7'd0, 8'hFF);
    send_item(1'b1, 8'hFF, 7'd0, 8'h00);
    wait_for_results();
  endtask

  task automatic test_payload_extremes;
    send_item(1'b1, 8'hFF, 7'd1, 8'h00);
    send_item(1'b1, 8'h00, 7'd1, 8'hFF);
    send_item(1'b1, 8'h5A, 7'd2, 8'h80);
    send_item(1'b0, 8'h7F, 7'h7F, 8'h01);
    wait_for_results();
  endtask

  task automatic test_length_saturation;
    send_item(1'b1, 8'h11, 7'd65, 8'hAA);
    send_item(1'b0, 8'h00, 7'd0, 8'h55);
    send_item(1'b1, 8'h22, 7'd127, 8'h55);
    send_item(1'b0, 8'hFF, 7'd127, 8'hAA);
    send_item(1'b1, 8'h33, 7'd0, 8'h00);
    wait_for_results();
  endtask

  task automatic test_frame_restart;
    send_item(1'b1, 8'h44, 7'd3, 8'h01);
    send_item(1'b0, 8'h00, 7'd0, 8'h02);
    send_item(1'b1, 8'h45, 7'd1, 8'h03);
    wait_for_results();
  endtask

  task automatic test_stray_items;
    send_item(1'b0, 8'hFF, 7'h7F, 8'hFF);
    send_item(1'b0, 8'h00, 7'd0, 8'h00);
    wait_for_results();
  endtask

  task automatic test_register_extremes;
    write_all_registers(8'hFF, 8'hFF, 8'hFF);
    send_item(1'b1, 8'hC3, 7'd1, 8'h3C);
    wait_for_results();
    write_all_registers(8'h00, 8'h00, 8'h00);
    send_item(1'b1, 8'h00, 7'd0, 8'h00);
    wait_for_results();
  endtask

  task automatic test_midframe_register_write;
    send_item(1'b1, 8'h66, 7'd2, 8'h11);
    wait_for_results();
    write_all_registers(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                        8'($urandom_range(0, 255)));
    send_item(1'b0, 8'h00, 7'd0, 8'h22);
    send_item(1'b1, 8'h67, 7'd0, 8'h33);
    wait_for_results();
  endtask

  function automatic logic [6:0] pick_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 7'($urandom_range(0, 4));
    if (r < 80) return 7'($urandom_range(5, 16));
    if (r < 92) return 7'($urandom_range(17, MaxPayload));
    if (r < 96) return 7'(MaxPayload);
    return 7'($urandom_range(MaxPayload + 1, 127));
  endfunction

  task automatic test_random_frames;
    int         sent;
    int         n_items;
    logic [6:0] len;
    sent = 0;
    while (sent < RandomItems) begin
      if ($urandom_range(0, 9) == 0)
        send_item(1'b0, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)),
                  8'($urandom_range(0, 255)));
      len = pick_length();
      n_items = (len == 7'd0) ? 1 : ((len > MaxPayload) ? MaxPayload : len);
      if (n_items > 1 && $urandom_range(0, 9) == 0)
        n_items = $urandom_range(1, n_items - 1);
      for (int k = 0; k < n_items; k++) begin
        send_item(k == 0, 8'($urandom_range(0, 255)),
                  (k == 0) ? len : 7'($urandom_range(0, 127)),
                  8'($urandom_range(0, 255)));
        sent++;
      end
      if ($urandom_range(0, 11) == 0) begin
        wait_for_results();
        write_all_registers(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                            8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = cfb_pkg::REG_HEADER;
    cfg_wdata       = 8'h00;
    in_valid        = 1'b0;
    in_first_item   = 1'b0;
    in_instruction  = 8'h00;
    in_payload_len  = 7'd0;
    in_payload_byte = 8'h00;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_zero_length();
    test_payload_extremes();
    test_length_saturation();
    test_frame_restart();
    test_stray_items();
    test_register_extremes();
    test_midframe_register_write();
    test_random_frames();
    wait_for_results();
    if (mismatches == 0) begin
      $display("** command_frame_builder_xor: PASSED **");
    end else begin
      $display("** command_frame_builder_xor: FAILED **");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("[%0t] timeout with %0d beats outstanding", $time, expected_bytes.size());
    $display("** command_frame_builder_xor: FAILED **");
    $finish;
  end

endmodule
